### hw/rtl/rk512_pkg.sv
// Shared types, codes and helper functions of the fetch/store telegram engine.
// Used by rk512_front, rk512_jobq, rk512_back and rk512_telegram_engine.
// No dependencies.
package rk512_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_FETCH = 2'd0,
    CMD_STORE = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_RX    = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic REG_LOCAL_ID = 1'b0;
  localparam logic REG_REPLY_ID = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_RX     = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FETCH_ST = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  // Telegram constants
  localparam logic [7:0]  HDR_FETCH   = 8'h45;
  localparam logic [7:0]  HDR_STORE   = 8'h41;
  localparam logic [7:0]  HDR_DIR     = 8'h44;
  localparam logic [7:0]  HDR_END     = 8'hFF;
  localparam logic [7:0]  BLK_SPECIAL = 8'h42;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  // Job queue geometry
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = 2;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_FETCH_HDR  = 3'd1,
    PH_FETCH_DATA = 3'd2,
    PH_STORE_DATA = 3'd3,
    PH_STORE_ACK  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    JOB_FETCH_HDR = 3'd0,
    JOB_STORE_HDR = 3'd1,
    JOB_DATA      = 3'd2,
    JOB_PAYLOAD   = 3'd3,
    JOB_STATUS    = 3'd4
  } job_op_t;

  // One unit of work from front to back
  typedef struct packed {
    job_op_t     op;
    logic [7:0]  byte_v;   // block number or data byte
    logic [15:0] size;     // size field of a request header
    logic [7:0]  lid;      // station byte of a request header
    logic        tail;     // append CRC bytes after this job
    logic [1:0]  status;
    logic [16:0] plen;
  } job_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Byte k of a 10-byte request header
  function automatic logic [7:0] hdr_byte(logic [7:0] op_char, logic [7:0] blk,
                                          logic [15:0] sz, logic [7:0] lid,
                                          logic [3:0] k);
    logic [7:0] v;
    case (k)
      4'd2:    v = op_char;
      4'd3:    v = HDR_DIR;
      4'd4:    v = blk;
      4'd6:    v = sz[15:8];
      4'd7:    v = sz[7:0];
      4'd8:    v = HDR_END;
      4'd9:    v = lid;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/rk512_front.sv
// Front end: config registers, exchange phase tracking, reply header check.
// Classifies each accepted item into at most one job for the back end.
// Depends on rk512_pkg.
module rk512_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_block_id,
  input  logic [15:0]        in_length,
  input  logic [7:0]         in_byte_value,
  output logic               job_valid,
  output rk512_pkg::job_t    job
);

  logic [7:0]        local_id_r, reply_id_r;
  rk512_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]        byte_count_r, byte_count_nxt;
  logic              header_error_r, header_error_nxt;
  logic              header_mismatch_r, header_mismatch_nxt;
  logic [15:0]       reply_size_r, reply_size_nxt;
  logic [7:0]        request_block_r, request_block_nxt;
  logic [15:0]       request_size_r, request_size_nxt;
  logic [16:0]       remaining_r, remaining_nxt;

  logic [15:0]       store_size;
  logic [15:0]       size_sel;
  logic [16:0]       plen_calc;
  logic              herr_now, hmis_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_id_r <= 8'h00;
      reply_id_r <= 8'h00;
    end else if (cfg_we) begin
      if (cfg_index == rk512_pkg::REG_LOCAL_ID) begin
        local_id_r <= cfg_data;
      end else begin
        reply_id_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= rk512_pkg::PH_IDLE;
      byte_count_r      <= 4'd0;
      header_error_r    <= 1'b0;
      header_mismatch_r <= 1'b0;
      reply_size_r      <= 16'd0;
      request_block_r   <= 8'd0;
      request_size_r    <= 16'd0;
      remaining_r       <= 17'd0;
    end else begin
      phase_r           <= phase_nxt;
      byte_count_r      <= byte_count_nxt;
      header_error_r    <= header_error_nxt;
      header_mismatch_r <= header_mismatch_nxt;
      reply_size_r      <= reply_size_nxt;
      request_block_r   <= request_block_nxt;
      request_size_r    <= request_size_nxt;
      remaining_r       <= remaining_nxt;
    end
  end

  always_comb begin
    store_size = (in_block_id == rk512_pkg::BLK_SPECIAL && in_length == 16'd4) ?
                 16'd6 : in_length;
    size_sel   = (reply_size_r != 16'd0) ? reply_size_r : request_size_r;
    plen_calc  = (size_sel >= 16'd4) ? ({size_sel, 1'b0} - 17'd8) : 17'd0;
    herr_now   = header_error_r;
    hmis_now   = header_mismatch_r;

    phase_nxt           = phase_r;
    byte_count_nxt      = byte_count_r;
    header_error_nxt    = header_error_r;
    header_mismatch_nxt = header_mismatch_r;
    reply_size_nxt      = reply_size_r;
    request_block_nxt   = request_block_r;
    request_size_nxt    = request_size_r;
    remaining_nxt       = remaining_r;
    job_valid           = 1'b0;
    job                 = '0;

    if (in_valid) begin
      case (rk512_pkg::cmd_t'(in_command))
        rk512_pkg::CMD_FETCH: begin
          job_valid           = 1'b1;
          job.op              = rk512_pkg::JOB_FETCH_HDR;
          job.byte_v          = in_block_id;
          job.size            = in_length;
          job.lid             = local_id_r;
          request_block_nxt   = in_block_id;
          request_size_nxt    = in_length;
          phase_nxt           = rk512_pkg::PH_FETCH_HDR;
          byte_count_nxt      = 4'd0;
          header_error_nxt    = 1'b0;
          header_mismatch_nxt = 1'b0;
          reply_size_nxt      = 16'd0;
          remaining_nxt       = 17'd0;
        end
        rk512_pkg::CMD_STORE: begin
          job_valid           = 1'b1;
          job.op              = rk512_pkg::JOB_STORE_HDR;
          job.byte_v          = in_block_id;
          job.size            = store_size;
          job.lid             = local_id_r;
          job.tail            = (in_length == 16'd0);
          request_block_nxt   = in_block_id;
          request_size_nxt    = store_size;
          remaining_nxt       = {1'b0, in_length};
          header_error_nxt    = 1'b0;
          header_mismatch_nxt = 1'b0;
          byte_count_nxt      = 4'd0;
          phase_nxt           = (in_length == 16'd0) ? rk512_pkg::PH_STORE_ACK :
                                                       rk512_pkg::PH_STORE_DATA;
        end
        rk512_pkg::CMD_DATA: begin
          if (phase_r == rk512_pkg::PH_STORE_DATA) begin
            job_valid     = 1'b1;
            job.op        = rk512_pkg::JOB_DATA;
            job.byte_v    = in_byte_value;
            job.tail      = (remaining_r <= 17'd1);
            remaining_nxt = (remaining_r != 17'd0) ? remaining_r - 17'd1 : 17'd0;
            if (remaining_r <= 17'd1) begin
              phase_nxt        = rk512_pkg::PH_STORE_ACK;
              byte_count_nxt   = 4'd0;
              header_error_nxt = 1'b0;
            end
          end
        end
        rk512_pkg::CMD_RX: begin
          if (phase_r == rk512_pkg::PH_FETCH_HDR) begin
            if (byte_count_r < 4'd4 && in_byte_value != 8'h00) begin
              herr_now = 1'b1;
            end
            if (byte_count_r == 4'd4 && in_byte_value != request_block_r) begin
              hmis_now = 1'b1;
            end
            if (byte_count_r == 4'd6) begin
              reply_size_nxt = {in_byte_value, reply_size_r[7:0]};
            end
            if (byte_count_r == 4'd7) begin
              reply_size_nxt = {reply_size_r[15:8], in_byte_value};
            end
            if (byte_count_r == 4'd9 && in_byte_value != reply_id_r) begin
              hmis_now = 1'b1;
            end
            header_error_nxt    = herr_now;
            header_mismatch_nxt = hmis_now;
            if (byte_count_r >= 4'd9) begin
              job_valid      = 1'b1;
              job.op         = rk512_pkg::JOB_STATUS;
              byte_count_nxt = 4'd0;
              if (herr_now) begin
                job.status = rk512_pkg::ST_FETCH_ST;
                phase_nxt  = rk512_pkg::PH_IDLE;
              end else if (hmis_now) begin
                job.status = rk512_pkg::ST_MISMATCH;
                phase_nxt  = rk512_pkg::PH_IDLE;
              end else begin
                job.status    = rk512_pkg::ST_OK;
                job.plen      = plen_calc;
                remaining_nxt = plen_calc;
                phase_nxt     = (plen_calc != 17'd0) ? rk512_pkg::PH_FETCH_DATA :
                                                       rk512_pkg::PH_IDLE;
              end
            end else begin
              byte_count_nxt = byte_count_r + 4'd1;
            end
          end else if (phase_r == rk512_pkg::PH_FETCH_DATA) begin
            job_valid     = 1'b1;
            job.op        = rk512_pkg::JOB_PAYLOAD;
            job.byte_v    = in_byte_value;
            remaining_nxt = (remaining_r != 17'd0) ? remaining_r - 17'd1 : 17'd0;
            if (remaining_r <= 17'd1) begin
              phase_nxt = rk512_pkg::PH_IDLE;
            end
          end else if (phase_r == rk512_pkg::PH_STORE_ACK) begin
            herr_now         = header_error_r | (in_byte_value != 8'h00);
            header_error_nxt = herr_now;
            if (byte_count_r >= 4'd3) begin
              job_valid      = 1'b1;
              job.op         = rk512_pkg::JOB_STATUS;
              job.status     = herr_now ? rk512_pkg::ST_REJECTED : rk512_pkg::ST_OK;
              phase_nxt      = rk512_pkg::PH_IDLE;
              byte_count_nxt = 4'd0;
            end else begin
              byte_count_nxt = byte_count_r + 4'd1;
            end
          end
        end
        default: begin
          job_valid = 1'b0;
        end
      endcase
    end
  end

endmodule

### hw/rtl/rk512_jobq.sv
// Short job queue between front and back end, register based.
// Depends on rk512_pkg.
module rk512_jobq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  rk512_pkg::job_t job_i,
  output logic            full_o,
  input  logic            pop_i,
  output rk512_pkg::job_t job_o,
  output logic            empty_o
);

  rk512_pkg::job_t                mem_r [rk512_pkg::JOBQ_DEPTH];
  logic [rk512_pkg::JOBQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [rk512_pkg::JOBQ_AW:0]   count_r, count_nxt;
  logic                          do_push, do_pop;

  assign full_o  = (count_r == (rk512_pkg::JOBQ_AW+1)'(rk512_pkg::JOBQ_DEPTH));
  assign empty_o = (count_r == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign job_o   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (rk512_pkg::JOBQ_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (rk512_pkg::JOBQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + (rk512_pkg::JOBQ_AW)'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + (rk512_pkg::JOBQ_AW)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= job_i;
    end
  end

endmodule

### hw/rtl/rk512_back.sv
// Back end: expands jobs into result items one per cycle while the output is free,
// keeps the running CRC and holds the output register. Depends on rk512_pkg.
module rk512_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rk512_pkg::job_t job,
  input  logic            job_empty,
  output logic            job_pop,
  output logic            out_valid,
  input  logic            out_take,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte_value_res,
  output logic [1:0]      out_status,
  output logic [16:0]     out_payload_length,
  output logic            out_last
);

  logic [4:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        valid_r, valid_nxt;
  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic [1:0]  status_r;
  logic [16:0] plen_r;
  logic        last_r;

  logic        load;
  logic [1:0]  item_kind;
  logic [7:0]  item_byte;
  logic [1:0]  item_status;
  logic [16:0] item_plen;
  logic        item_last;
  logic [4:0]  hdr_pos;

  assign load    = ~job_empty & (~valid_r | out_take);
  assign job_pop = load & item_last;

  always_comb begin
    item_kind   = rk512_pkg::KIND_TX;
    item_byte   = 8'h00;
    item_status = rk512_pkg::ST_OK;
    item_plen   = 17'd0;
    item_last   = 1'b1;
    crc_nxt     = crc_r;
    // repeat bytes re-send header bytes 4..9
    hdr_pos     = (idx_r < 5'd10) ? idx_r : idx_r - 5'd6;

    case (job.op)
      rk512_pkg::JOB_FETCH_HDR: begin
        item_byte = rk512_pkg::hdr_byte(rk512_pkg::HDR_FETCH, job.byte_v, job.size,
                                        job.lid, hdr_pos[3:0]);
        item_last = (idx_r == 5'd9);
      end
      rk512_pkg::JOB_STORE_HDR: begin
        if (idx_r == 5'd16) begin
          item_byte = crc_r[7:0];
        end else if (idx_r == 5'd17) begin
          item_byte = crc_r[15:8];
        end else begin
          item_byte = rk512_pkg::hdr_byte(rk512_pkg::HDR_STORE, job.byte_v, job.size,
                                          job.lid, hdr_pos[3:0]);
        end
        item_last = job.tail ? (idx_r == 5'd17) : (idx_r == 5'd15);
        if (idx_r == 5'd0) begin
          crc_nxt = rk512_pkg::CRC_INIT;
        end else if (idx_r >= 5'd10 && idx_r <= 5'd15) begin
          crc_nxt = rk512_pkg::crc_byte(crc_r, item_byte);
        end
      end
      rk512_pkg::JOB_DATA: begin
        if (idx_r == 5'd1) begin
          item_byte = crc_r[7:0];
        end else if (idx_r == 5'd2) begin
          item_byte = crc_r[15:8];
        end else begin
          item_byte = job.byte_v;
          crc_nxt   = rk512_pkg::crc_byte(crc_r, job.byte_v);
        end
        item_last = job.tail ? (idx_r == 5'd2) : 1'b1;
      end
      rk512_pkg::JOB_PAYLOAD: begin
        item_kind = rk512_pkg::KIND_RX;
        item_byte = job.byte_v;
      end
      rk512_pkg::JOB_STATUS: begin
        item_kind   = rk512_pkg::KIND_STATUS;
        item_status = job.status;
        item_plen   = job.plen;
      end
      default: begin
        item_last = 1'b1;
      end
    endcase

    idx_nxt   = idx_r;
    valid_nxt = valid_r & ~out_take;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = item_last ? 5'd0 : idx_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 5'd0;
      crc_r   <= rk512_pkg::CRC_INIT;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
      if (load) begin
        crc_r <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= item_kind;
      byte_r   <= item_byte;
      status_r <= item_status;
      plen_r   <= item_plen;
      last_r   <= item_last;
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = kind_r;
  assign out_byte_value_res = byte_r;
  assign out_status         = status_r;
  assign out_payload_length = plen_r;
  assign out_last           = last_r;

endmodule

### hw/rtl/rk512_telegram_engine.sv
// Fetch/store telegram engine, top level. A request's jobs pass the job queue and
// then the back end's output register. One request per cycle while the four-entry
// job queue has room; the back end emits one result per cycle while results are popped:
// a fetch start gives 10 results, a store start 16 or 18, a data byte 1 or 3.
// Reset (rst_n, synchronous, active low) empties the job queue and output register,
// clears phase and configuration to zero and sets the CRC to 0xFFFF.
module rk512_telegram_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_block_id,
  input  logic [15:0] in_length,
  input  logic [7:0]  in_byte_value,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte_value_res,
  output logic [1:0]  out_status,
  output logic [16:0] out_payload_length,
  output logic        out_last
);

  logic            in_acc;
  logic            job_valid;
  rk512_pkg::job_t job_in, job_head;
  logic            job_empty, job_pop;
  logic            out_valid;

  assign in_acc = push & ~full;
  assign empty  = ~out_valid;

  rk512_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_acc),
    .in_command    (in_command),
    .in_block_id   (in_block_id),
    .in_length     (in_length),
    .in_byte_value (in_byte_value),
    .job_valid     (job_valid),
    .job           (job_in)
  );

  rk512_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (job_valid),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .job_o   (job_head),
    .empty_o (job_empty)
  );

  rk512_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job                (job_head),
    .job_empty          (job_empty),
    .job_pop            (job_pop),
    .out_valid          (out_valid),
    .out_take           (pop),
    .out_kind           (out_kind),
    .out_byte_value_res (out_byte_value_res),
    .out_status         (out_status),
    .out_payload_length (out_payload_length),
    .out_last           (out_last)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench for rk512_telegram_engine: fetch and store telegrams,
// reply headers and acknowledges checked against an in-bench predictor.
// Depends on rk512_pkg and the engine RTL only.
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [1:0]  status;
    logic [16:0] plen;
    logic        last;
  } telegram_result_t;

  // Optional hand-typed expectation for one request of the directed table
  typedef struct packed {
    logic             chk_count;
    logic             chk_tail;
    logic [4:0]       count;
    telegram_result_t tail;
  } row_check_t;

  typedef struct packed {
    rk512_pkg::cmd_t cmd;
    logic [7:0]      blk;
    logic [15:0]     len;
    logic [7:0]      bv;
    row_check_t      chk;
  } directed_row_t;

  localparam row_check_t NO_CHECK = '0;
  localparam int DIRECTED_ROWS = 25;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = rk512_pkg::REG_LOCAL_ID;
  logic [7:0]  cfg_data = 8'h00;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_command = rk512_pkg::CMD_FETCH;
  logic [7:0]  in_block_id = 8'h00;
  logic [15:0] in_length = 16'h0000;
  logic [7:0]  in_byte_value = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte_value_res;
  logic [1:0]  out_status;
  logic [16:0] out_payload_length;
  logic        out_last;

  row_check_t  row_check = NO_CHECK;

  // Predictor state
  rk512_pkg::phase_t tg_phase = rk512_pkg::PH_IDLE;
  logic [3:0]  hdr_idx = 4'd0;
  logic        status_bad = 1'b0;
  logic        echo_bad = 1'b0;
  logic [15:0] reply_size = 16'h0000;
  logic [7:0]  req_block = 8'h00;
  logic [15:0] req_size = 16'h0000;
  logic [16:0] remaining = 17'd0;
  logic [15:0] crc_acc = rk512_pkg::CRC_INIT;
  logic [7:0]  local_id_reg = 8'h00;
  logic [7:0]  reply_id_reg = 8'h00;

  telegram_result_t step_results[$];
  telegram_result_t results_due[$];
  telegram_result_t want;

  int          error_count = 0;
  int          stall_cycles = 0;
  int          items_sent = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_off = 1'b0;
  logic [7:0]  gen_reply_id = 8'h00;

  rk512_telegram_engine dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .push               (push),
    .full               (full),
    .in_command         (in_command),
    .in_block_id        (in_block_id),
    .in_length          (in_length),
    .in_byte_value      (in_byte_value),
    .empty              (empty),
    .pop                (pop),
    .out_kind           (out_kind),
    .out_byte_value_res (out_byte_value_res),
    .out_status         (out_status),
    .out_payload_length (out_payload_length),
    .out_last           (out_last)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("%0t: MISMATCH %s", $time, msg);
    end
    error_count++;
  endtask

  // CCITT CRC, one message bit at a time, MSB first
  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? rk512_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void add_result(input logic [1:0] kind, input logic [7:0] value,
                                     input logic [1:0] st, input logic [16:0] plen);
    telegram_result_t r;
    r = '{kind, value, st, plen, 1'b0};
    step_results = {step_results, r};
  endfunction

  function automatic void close_store();
    add_result(rk512_pkg::KIND_TX, crc_acc[7:0], rk512_pkg::ST_OK, 17'd0);
    add_result(rk512_pkg::KIND_TX, crc_acc[15:8], rk512_pkg::ST_OK, 17'd0);
    tg_phase = rk512_pkg::PH_STORE_ACK;
    hdr_idx = 4'd0;
    status_bad = 1'b0;
  endfunction

  // Work out the results of one accepted request and queue them
  task automatic predict_telegram(input rk512_pkg::cmd_t cmd, input logic [7:0] blk,
                                  input logic [15:0] len, input logic [7:0] bv);
    logic [79:0]      hdr;
    logic [15:0]      sz16;
    logic [16:0]      sz;
    logic [16:0]      plen;
    telegram_result_t r;
    step_results.delete();
    case (cmd)
      rk512_pkg::CMD_FETCH: begin
        hdr = {16'h0000, rk512_pkg::HDR_FETCH, rk512_pkg::HDR_DIR, blk, 8'h00, len,
               rk512_pkg::HDR_END, local_id_reg};
        for (int i = 0; i < 10; i++) begin
          add_result(rk512_pkg::KIND_TX, hdr[79 - 8 * i -: 8], rk512_pkg::ST_OK, 17'd0);
        end
        req_block = blk;
        req_size = len;
        tg_phase = rk512_pkg::PH_FETCH_HDR;
        hdr_idx = 4'd0;
        status_bad = 1'b0;
        echo_bad = 1'b0;
        reply_size = 16'h0000;
        remaining = 17'd0;
      end
      rk512_pkg::CMD_STORE: begin
        sz16 = (blk == rk512_pkg::BLK_SPECIAL && len == 16'd4) ? 16'd6 : len;
        hdr = {16'h0000, rk512_pkg::HDR_STORE, rk512_pkg::HDR_DIR, blk, 8'h00, sz16,
               rk512_pkg::HDR_END, local_id_reg};
        for (int i = 0; i < 10; i++) begin
          add_result(rk512_pkg::KIND_TX, hdr[79 - 8 * i -: 8], rk512_pkg::ST_OK, 17'd0);
        end
        // the repeat covers header bytes 4..9 and seeds the CRC
        crc_acc = rk512_pkg::CRC_INIT;
        for (int i = 4; i < 10; i++) begin
          add_result(rk512_pkg::KIND_TX, hdr[79 - 8 * i -: 8], rk512_pkg::ST_OK, 17'd0);
          crc_acc = crc_next(crc_acc, hdr[79 - 8 * i -: 8]);
        end
        req_block = blk;
        req_size = sz16;
        remaining = {1'b0, len};
        status_bad = 1'b0;
        echo_bad = 1'b0;
        hdr_idx = 4'd0;
        if (remaining == 17'd0) begin
          close_store();
        end else begin
          tg_phase = rk512_pkg::PH_STORE_DATA;
        end
      end
      rk512_pkg::CMD_DATA: begin
        if (tg_phase == rk512_pkg::PH_STORE_DATA) begin
          add_result(rk512_pkg::KIND_TX, bv, rk512_pkg::ST_OK, 17'd0);
          crc_acc = crc_next(crc_acc, bv);
          if (remaining != 17'd0) begin
            remaining = remaining - 17'd1;
          end
          if (remaining == 17'd0) begin
            close_store();
          end
        end
      end
      default: begin
        case (tg_phase)
          rk512_pkg::PH_FETCH_HDR: begin
            if (hdr_idx < 4'd4 && bv != 8'h00) begin
              status_bad = 1'b1;
            end
            if (hdr_idx == 4'd4 && bv != req_block) begin
              echo_bad = 1'b1;
            end
            if (hdr_idx == 4'd6) begin
              reply_size[15:8] = bv;
            end
            if (hdr_idx == 4'd7) begin
              reply_size[7:0] = bv;
            end
            if (hdr_idx == 4'd9 && bv != reply_id_reg) begin
              echo_bad = 1'b1;
            end
            if (hdr_idx >= 4'd9) begin
              if (status_bad) begin
                add_result(rk512_pkg::KIND_STATUS, 8'h00, rk512_pkg::ST_FETCH_ST, 17'd0);
                tg_phase = rk512_pkg::PH_IDLE;
              end else if (echo_bad) begin
                add_result(rk512_pkg::KIND_STATUS, 8'h00, rk512_pkg::ST_MISMATCH, 17'd0);
                tg_phase = rk512_pkg::PH_IDLE;
              end else begin
                // a zero size field falls back to the requested size
                sz = (reply_size != 16'h0000) ? {1'b0, reply_size} : {1'b0, req_size};
                plen = (sz >= 17'd4) ? (sz << 1) - 17'd8 : 17'd0;
                add_result(rk512_pkg::KIND_STATUS, 8'h00, rk512_pkg::ST_OK, plen);
                remaining = plen;
                tg_phase = (plen != 17'd0) ? rk512_pkg::PH_FETCH_DATA : rk512_pkg::PH_IDLE;
              end
              hdr_idx = 4'd0;
            end else begin
              hdr_idx = hdr_idx + 4'd1;
            end
          end
          rk512_pkg::PH_FETCH_DATA: begin
            add_result(rk512_pkg::KIND_RX, bv, rk512_pkg::ST_OK, 17'd0);
            if (remaining != 17'd0) begin
              remaining = remaining - 17'd1;
            end
            if (remaining == 17'd0) begin
              tg_phase = rk512_pkg::PH_IDLE;
            end
          end
          rk512_pkg::PH_STORE_ACK: begin
            if (bv != 8'h00) begin
              status_bad = 1'b1;
            end
            if (hdr_idx >= 4'd3) begin
              add_result(rk512_pkg::KIND_STATUS, 8'h00,
                         status_bad ? rk512_pkg::ST_REJECTED : rk512_pkg::ST_OK, 17'd0);
              tg_phase = rk512_pkg::PH_IDLE;
              hdr_idx = 4'd0;
            end else begin
              hdr_idx = hdr_idx + 4'd1;
            end
          end
          default: begin
          end
        endcase
      end
    endcase
    if (step_results.size() != 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results = {step_results, r};
    end
    results_due = {results_due, step_results};
  endtask

  // Track every handshake: predict on accepted requests, check popped results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == rk512_pkg::REG_LOCAL_ID) begin
          local_id_reg = cfg_data;
        end else begin
          reply_id_reg = cfg_data;
        end
      end
      if (push && !full) begin
        predict_telegram(rk512_pkg::cmd_t'(in_command), in_block_id, in_length,
                         in_byte_value);
        if (row_check.chk_count && step_results.size() != row_check.count) begin
          report_mismatch($sformatf("request gives %0d results, table says %0d",
                                    step_results.size(), row_check.count));
        end
        if (row_check.chk_tail &&
            (step_results.size() == 0 || step_results[$] != row_check.tail)) begin
          report_mismatch("predicted final result differs from table");
        end
      end
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result kind %0d byte %02h with nothing expected",
                                    out_kind, out_byte_value_res));
        end else begin
          want = results_due.pop_front();
          if (out_kind !== want.kind) begin
            report_mismatch($sformatf("kind got %0d want %0d", out_kind, want.kind));
          end
          if (out_byte_value_res !== want.value) begin
            report_mismatch($sformatf("byte got %02h want %02h",
                                      out_byte_value_res, want.value));
          end
          if (out_status !== want.status) begin
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          end
          if (out_payload_length !== want.plen) begin
            report_mismatch($sformatf("payload length got %0d want %0d",
                                      out_payload_length, want.plen));
          end
          if (out_last !== want.last) begin
            report_mismatch($sformatf("last got %0b want %0b", out_last, want.last));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random pops, plus one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_request(input rk512_pkg::cmd_t cmd, input logic [7:0] blk,
                              input logic [15:0] len, input logic [7:0] bv,
                              input row_check_t chk);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_command <= cmd;
    in_block_id <= blk;
    in_length <= len;
    in_byte_value <= bv;
    row_check <= chk;
    do @(posedge clk); while (full);
  endtask

  task automatic send_counted(input rk512_pkg::cmd_t cmd, input logic [7:0] blk,
                              input logic [15:0] len, input logic [7:0] bv);
    send_request(cmd, blk, len, bv, NO_CHECK);
    items_sent++;
  endtask

  task automatic write_registers(input logic [7:0] lid, input logic [7:0] rid);
    cfg_we <= 1'b1;
    cfg_index <= rk512_pkg::REG_LOCAL_ID;
    cfg_data <= lid;
    @(posedge clk);
    cfg_index <= rk512_pkg::REG_REPLY_ID;
    cfg_data <= rid;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_reply_id = rid;
  endtask

  // Let queued results drain, then allow for requests still in the pipe
  task automatic drain_results();
    push <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic row_check_t only_count(input int n);
    row_check_t c;
    c = NO_CHECK;
    c.chk_count = 1'b1;
    c.count = 5'(n);
    return c;
  endfunction

  function automatic row_check_t with_tail(input int n, input logic [1:0] kind,
                                           input logic [7:0] value, input logic [1:0] st,
                                           input logic [16:0] plen);
    row_check_t c;
    c.chk_count = 1'b1;
    c.chk_tail = 1'b1;
    c.count = 5'(n);
    c.tail = '{kind, value, st, plen, 1'b1};
    return c;
  endfunction

  // Directed table; station bytes are local 0xFF, reply 0x00 while it runs
  function automatic directed_row_t directed_row(input int i);
    directed_row_t r;
    r = '{rk512_pkg::CMD_RX, 8'h00, 16'h0000, 8'h00, only_count(0)};
    case (i)
      0:  r = '{rk512_pkg::CMD_RX,    8'h00, 16'h0000, 8'hFF, only_count(0)};
      1:  r = '{rk512_pkg::CMD_DATA,  8'hFF, 16'hFFFF, 8'hAA, only_count(0)};
      2:  r = '{rk512_pkg::CMD_FETCH, 8'h00, 16'hFFFF, 8'h00,
                with_tail(10, rk512_pkg::KIND_TX, 8'hFF, rk512_pkg::ST_OK, 17'd0)};
      8:  r = '{rk512_pkg::CMD_RX,    8'h00, 16'h0000, 8'hFF, only_count(0)};
      11: r = '{rk512_pkg::CMD_RX,    8'h00, 16'h0000, 8'hFF, only_count(0)};
      12: r = '{rk512_pkg::CMD_RX,    8'h00, 16'h0000, 8'h00,
                with_tail(1, rk512_pkg::KIND_STATUS, 8'h00, rk512_pkg::ST_OK, 17'd131062)};
      13: r = '{rk512_pkg::CMD_RX,    8'h00, 16'h0000, 8'h80,
                with_tail(1, rk512_pkg::KIND_RX, 8'h80, rk512_pkg::ST_OK, 17'd0)};
      14: r = '{rk512_pkg::CMD_STORE, rk512_pkg::BLK_SPECIAL, 16'd4, 8'h00,
                with_tail(16, rk512_pkg::KIND_TX, 8'hFF, rk512_pkg::ST_OK, 17'd0)};
      15: r = '{rk512_pkg::CMD_RX,    8'h00, 16'h0000, 8'h5A, only_count(0)};
      16: r = '{rk512_pkg::CMD_DATA,  8'h00, 16'h0000, 8'h00,
                with_tail(1, rk512_pkg::KIND_TX, 8'h00, rk512_pkg::ST_OK, 17'd0)};
      17: r = '{rk512_pkg::CMD_DATA,  8'h00, 16'h0000, 8'hFF,
                with_tail(1, rk512_pkg::KIND_TX, 8'hFF, rk512_pkg::ST_OK, 17'd0)};
      18: r = '{rk512_pkg::CMD_DATA,  8'h00, 16'h0000, 8'h01,
                with_tail(1, rk512_pkg::KIND_TX, 8'h01, rk512_pkg::ST_OK, 17'd0)};
      19: r = '{rk512_pkg::CMD_DATA,  8'h00, 16'h0000, 8'h80, only_count(3)};
      20: r = '{rk512_pkg::CMD_STORE, 8'hFF, 16'h0000, 8'h00, only_count(18)};
      22: r = '{rk512_pkg::CMD_RX,    8'h00, 16'h0000, 8'h01, only_count(0)};
      24: r = '{rk512_pkg::CMD_RX,    8'h00, 16'h0000, 8'h00,
                with_tail(1, rk512_pkg::KIND_STATUS, 8'h00, rk512_pkg::ST_REJECTED, 17'd0)};
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic run_fetch();
    logic [7:0]  blk;
    logic [15:0] req_len;
    logic [7:0]  rx_hdr [10];
    logic [16:0] sz;
    logic [16:0] plen;
    int          cut;
    int          n;
    blk = 8'($urandom_range(255));
    case ($urandom_range(9))
      0, 1:    req_len = 16'd0;
      2:       req_len = 16'($urandom_range(13, 40));
      3:       req_len = 16'($urandom);
      default: req_len = 16'($urandom_range(0, 12));
    endcase
    send_counted(rk512_pkg::CMD_FETCH, blk, req_len, 8'($urandom_range(255)));
    for (int i = 0; i < 10; i++) begin
      rx_hdr[i] = 8'($urandom_range(255));
    end
    for (int i = 0; i < 4; i++) begin
      rx_hdr[i] = 8'h00;
    end
    if ($urandom_range(9) == 0) begin
      rx_hdr[$urandom_range(3)] = 8'($urandom_range(1, 255));
    end
    rx_hdr[4] = ($urandom_range(9) == 0) ? blk ^ 8'($urandom_range(1, 255)) : blk;
    case ($urandom_range(9))
      0, 1, 2, 3: {rx_hdr[6], rx_hdr[7]} = 16'h0000;
      8:          {rx_hdr[6], rx_hdr[7]} = 16'($urandom_range(13, 40));
      9:          {rx_hdr[6], rx_hdr[7]} = 16'($urandom);
      default:    {rx_hdr[6], rx_hdr[7]} = 16'($urandom_range(0, 12));
    endcase
    rx_hdr[9] = ($urandom_range(11) == 0) ? gen_reply_id ^ 8'($urandom_range(1, 255))
                                          : gen_reply_id;
    // now and then break off the reply header; the next start drops it
    cut = ($urandom_range(19) == 0) ? $urandom_range(9) : 10;
    for (int i = 0; i < cut; i++) begin
      send_counted(rk512_pkg::CMD_RX, 8'($urandom_range(255)), 16'($urandom), rx_hdr[i]);
    end
    if (cut < 10 || (|{rx_hdr[0], rx_hdr[1], rx_hdr[2], rx_hdr[3]}) ||
        rx_hdr[4] != blk || rx_hdr[9] != gen_reply_id) begin
      return;
    end
    sz = ({rx_hdr[6], rx_hdr[7]} != 16'h0000) ? {1'b0, rx_hdr[6], rx_hdr[7]}
                                              : {1'b0, req_len};
    plen = (sz >= 17'd4) ? (sz << 1) - 17'd8 : 17'd0;
    n = (plen > 17'd16) ? $urandom_range(1, 16) : int'(plen);
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(0, n);
    end
    for (int i = 0; i < n; i++) begin
      send_counted(rk512_pkg::CMD_RX, 8'($urandom_range(255)), 16'($urandom),
                   8'($urandom_range(255)));
    end
  endtask

  task automatic run_store();
    logic [7:0]  blk;
    logic [15:0] len;
    logic [7:0]  ack [4];
    int          n;
    int          cut;
    blk = ($urandom_range(4) == 0) ? rk512_pkg::BLK_SPECIAL : 8'($urandom_range(255));
    case ($urandom_range(9))
      0:       len = 16'd0;
      1:       len = 16'd4;
      2:       len = 16'($urandom);
      default: len = 16'($urandom_range(1, 10));
    endcase
    send_counted(rk512_pkg::CMD_STORE, blk, len, 8'($urandom_range(255)));
    n = (len > 16'd12) ? $urandom_range(1, 12) : int'(len);
    if ($urandom_range(11) == 0) begin
      n = $urandom_range(0, n);
    end
    for (int i = 0; i < n; i++) begin
      send_counted(rk512_pkg::CMD_DATA, 8'($urandom_range(255)), 16'($urandom),
                   8'($urandom_range(255)));
    end
    if (n != int'(len)) begin
      return;
    end
    for (int i = 0; i < 4; i++) begin
      ack[i] = 8'h00;
    end
    if ($urandom_range(4) == 0) begin
      ack[$urandom_range(3)] = 8'($urandom_range(1, 255));
    end
    cut = ($urandom_range(19) == 0) ? $urandom_range(3) : 4;
    for (int i = 0; i < cut; i++) begin
      send_counted(rk512_pkg::CMD_RX, 8'($urandom_range(255)), 16'($urandom), ack[i]);
    end
  endtask

  task automatic run_noise();
    send_counted(rk512_pkg::cmd_t'($urandom_range(3)), 8'($urandom_range(255)),
                 ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12)),
                 8'($urandom_range(255)));
  endtask

  task automatic run_random(input int count, input int s_idle, input int r_idle,
                            input bit with_hold);
    int start;
    bit held;
    send_idle = s_idle;
    recv_idle = r_idle;
    start = items_sent;
    held = 1'b0;
    while (items_sent - start < count) begin
      // stop draining for a while so the request side backs up
      if (with_hold && !held && items_sent - start >= count / 3) begin
        hold_off = 1'b1;
        held = 1'b1;
      end
      case ($urandom_range(19))
        0, 1:                      run_noise();
        2, 3, 4, 5, 6, 7, 8, 9, 10: run_fetch();
        default:                   run_store();
      endcase
    end
    drain_results();
  endtask

  initial begin
    directed_row_t row;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_registers(8'hFF, 8'h00);
    send_idle = 16;
    recv_idle = 47;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_row(i);
      send_request(row.cmd, row.blk, row.len, row.bv, row.chk);
    end
    drain_results();
    write_registers(8'h00, 8'hFF);
    run_random(140, 16, 47, 1'b1);
    write_registers(8'($urandom_range(255)), 8'($urandom_range(255)));
    run_random(140, 47, 16, 1'b0);
    write_registers(8'h5A, 8'hA5);
    run_random(140, 0, 0, 1'b1);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
